/* hdl/dq_pkg.sv */
// Shared types, codes and sizes for the double-ended queue.
`timescale 1ns / 1ps
package dq_pkg;

  localparam int DEPTH  = 16;
  localparam int DATA_W = 32;
  localparam int OCC_W  = 5;
  localparam int CNT_W  = $clog2(DEPTH + 1);

  typedef logic [1:0]              opcode_t;
  typedef logic [1:0]              status_t;
  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic [OCC_W-1:0]        occ_t;
  typedef logic [CNT_W-1:0]        cnt_t;

  localparam opcode_t OP_PUSH_REAR  = 2'd0;
  localparam opcode_t OP_POP_FRONT  = 2'd1;
  localparam opcode_t OP_PUSH_FRONT = 2'd2;
  localparam opcode_t OP_POP_REAR   = 2'd3;

  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_EMPTY = 2'd1;
  localparam status_t ST_FULL  = 2'd2;

  // Operation broadcast to every cell; at most one strobe is high.
  typedef struct packed {
    logic  push_rear;
    logic  pop_front;
    logic  push_front;
    logic  pop_rear;
    data_t push_value;
  } ctl_t;

endpackage

/* hdl/dq_if.sv */
// Valid/ready channel interfaces for the queue's operation and result streams.
`timescale 1ns / 1ps
interface dq_in_if;
  logic               valid;
  logic               ready;
  dq_pkg::opcode_t    opcode;
  dq_pkg::data_t      push_value;

  modport source (output valid, output opcode, output push_value, input ready);
  modport sink   (input valid, input opcode, input push_value, output ready);
endinterface

interface dq_out_if;
  logic               valid;
  logic               ready;
  dq_pkg::data_t      pop_value;
  dq_pkg::status_t    status;
  dq_pkg::occ_t       occupancy;

  modport source (output valid, output pop_value, output status, output occupancy,
                  input ready);
  modport sink   (input valid, input pop_value, input status, input occupancy,
                  output ready);
endinterface

/* hdl/double_ended_queue.sv */
// Top level of the double-ended queue: cell row, operation decode and result register.
`timescale 1ns / 1ps
// Bounded deque of signed 32-bit entries (dq_pkg::DEPTH of them).
// in_ch carries one operation per transfer: opcode (push rear, pop front,
// push front, pop rear) and push_value. out_ch returns exactly one result
// per operation: pop_value, status (ok / empty / full) and occupancy after
// the operation.
// Storage is a row of identical cells. Entries sit packed from cell 0
// (front) upward; a front push or pop shifts the whole row by one cell,
// a rear push fills the first empty cell, and a rear pop
// clears the last full one. The rear entry is picked out by an OR of the
// per-cell tail taps.
// The result is loaded into the output register on the operation
// transfer. Throughput: one operation every cycle while out_ch takes
// results, as the whole cell row updates on each transfer.
// Reset (synchronous, rst_n low) empties the queue: all cell valid flags
// and the count clear, the output register goes invalid.
// Stall: while a result waits and out_ch.ready is low, in_ch.ready drops;
// when out_ch.ready is high a new operation is taken in the same cycle the
// waiting result leaves.
module double_ended_queue (
  input  logic     clk,
  input  logic     rst_n,
  dq_in_if.sink    in_ch,
  dq_out_if.source out_ch
);

  localparam int DEPTH = dq_pkg::DEPTH;

  // Cell row
  logic [DEPTH-1:0] vld;
  dq_pkg::data_t    val      [DEPTH];
  dq_pkg::data_t    tail_val [DEPTH];
  dq_pkg::ctl_t     ctl;

  // Decode
  logic          in_fire;
  logic          is_push;
  logic          q_full;
  logic          q_empty;
  logic          op_ok;
  dq_pkg::data_t tail_or;

  // Count and result register
  dq_pkg::cnt_t    cnt_r, cnt_nxt;
  logic            out_valid_r, out_valid_nxt;
  dq_pkg::data_t   out_pop_r, out_pop_nxt;
  dq_pkg::status_t out_status_r, out_status_nxt;
  dq_pkg::occ_t    out_occ_r, out_occ_nxt;

  // Take a new operation whenever the result slot is free or draining.
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_fire     = in_ch.valid && in_ch.ready;

  assign is_push = (in_ch.opcode == dq_pkg::OP_PUSH_REAR) ||
                   (in_ch.opcode == dq_pkg::OP_PUSH_FRONT);
  assign q_full  = vld[DEPTH-1];
  assign q_empty = !vld[0];
  assign op_ok   = is_push ? !q_full : !q_empty;

  // Strobes go only to operations that change state.
  assign ctl.push_rear  = in_fire && op_ok && (in_ch.opcode == dq_pkg::OP_PUSH_REAR);
  assign ctl.pop_front  = in_fire && op_ok && (in_ch.opcode == dq_pkg::OP_POP_FRONT);
  assign ctl.push_front = in_fire && op_ok && (in_ch.opcode == dq_pkg::OP_PUSH_FRONT);
  assign ctl.pop_rear   = in_fire && op_ok && (in_ch.opcode == dq_pkg::OP_POP_REAR);
  assign ctl.push_value = in_ch.push_value;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    dq_pkg::data_t lv, rv;
    logic          lvd, rvd;

    // Head cell's left neighbor is the incoming value, always valid.
    if (i == 0) begin : g_head
      assign lv  = ctl.push_value;
      assign lvd = 1'b1;
    end else begin : g_left
      assign lv  = val[i-1];
      assign lvd = vld[i-1];
    end

    // Past the last cell nothing is held.
    if (i == DEPTH - 1) begin : g_last
      assign rv  = '0;
      assign rvd = 1'b0;
    end else begin : g_right
      assign rv  = val[i+1];
      assign rvd = vld[i+1];
    end

    dq_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .left_val  (lv),
      .left_vld  (lvd),
      .right_val (rv),
      .right_vld (rvd),
      .val       (val[i]),
      .vld       (vld[i]),
      .tail_val  (tail_val[i])
    );
  end

  // Only the rear cell drives a nonzero tap.
  always_comb begin
    tail_or = '0;
    for (int i = 0; i < DEPTH; i++) begin
      tail_or = tail_or | tail_val[i];
    end
  end

  always_comb begin
    cnt_nxt        = cnt_r;
    out_pop_nxt    = '0;
    out_status_nxt = dq_pkg::ST_OK;
    if (is_push) begin
      if (q_full) begin
        out_status_nxt = dq_pkg::ST_FULL;
      end else begin
        cnt_nxt = cnt_r + dq_pkg::cnt_t'(1);
      end
    end else begin
      if (q_empty) begin
        out_status_nxt = dq_pkg::ST_EMPTY;
      end else begin
        cnt_nxt     = cnt_r - dq_pkg::cnt_t'(1);
        out_pop_nxt = (in_ch.opcode == dq_pkg::OP_POP_FRONT) ? val[0] : tail_or;
      end
    end
    out_occ_nxt = dq_pkg::occ_t'(cnt_nxt);
  end

  always_comb begin
    if (in_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_fire) begin
        cnt_r <= cnt_nxt;
      end
    end
  end

  // Result payload, loaded on each operation transfer.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_pop_r    <= out_pop_nxt;
      out_status_r <= out_status_nxt;
      out_occ_r    <= out_occ_nxt;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.pop_value = out_pop_r;
  assign out_ch.status    = out_status_r;
  assign out_ch.occupancy = out_occ_r;

`ifndef SYNTHESIS
  // Cell valid flags always agree with the entry count.
  a_cnt_matches_cells: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(vld) == int'(cnt_r))
    else $error("cell valid flags disagree with entry count");

  // Occupied cells stay packed against the front.
  a_cells_packed: assert property (@(posedge clk) disable iff (!rst_n)
    ((vld >> 1) & ~vld) == '0)
    else $error("gap in occupied cells");

  // A dropped push leaves the count untouched.
  a_full_push_holds: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && is_push && q_full |=> $stable(cnt_r))
    else $error("push on full queue changed the count");

  // A waiting result reports the current count.
  a_occ_tracks_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_occ_r == dq_pkg::occ_t'(cnt_r))
    else $error("reported occupancy differs from count");

  // Failed operations return zero.
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r != dq_pkg::ST_OK |-> out_pop_r == '0)
    else $error("failed operation returned a value");
`endif

endmodule

/* hdl/dq_cell.sv */
// One storage cell of the shifting deque: holds an entry and trades with neighbors.
`timescale 1ns / 1ps
module dq_cell (
  input  logic          clk,
  input  logic          rst_n,
  input  dq_pkg::ctl_t  ctl,
  input  dq_pkg::data_t left_val,
  input  logic          left_vld,
  input  dq_pkg::data_t right_val,
  input  logic          right_vld,
  output dq_pkg::data_t val,
  output logic          vld,
  output dq_pkg::data_t tail_val
);

  dq_pkg::data_t val_r, val_nxt;
  logic          vld_r, vld_nxt;

  always_comb begin
    val_nxt = val_r;
    vld_nxt = vld_r;
    if (ctl.push_front) begin
      val_nxt = left_val;
      vld_nxt = left_vld;
    end else if (ctl.pop_front) begin
      val_nxt = right_val;
      vld_nxt = right_vld;
    end else if (ctl.push_rear) begin
      // first empty cell takes the value
      if (!vld_r && left_vld) begin
        val_nxt = ctl.push_value;
        vld_nxt = 1'b1;
      end
    end else if (ctl.pop_rear) begin
      if (vld_r && !right_vld) begin
        vld_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign val      = val_r;
  assign vld      = vld_r;
  assign tail_val = (vld_r && !right_vld) ? val_r : '0;

endmodule

/* test/double_ended_queue_tb.sv */
// Testbench for double_ended_queue: directed and random deque traffic checked per result.
`timescale 1ns / 1ps
module double_ended_queue_tb;
  import dq_pkg::*;

  // Watchdog in ns. A full run takes well under a quarter of this.
  localparam int unsigned LIMIT_NS = 4_000_000;

  localparam data_t VAL_MIN = data_t'(32'h8000_0000);
  localparam data_t VAL_MAX = data_t'(32'h7FFF_FFFF);

  typedef struct packed {
    data_t   pop_value;
    status_t status;
    occ_t    occupancy;
  } dq_result_t;

  // Receiver behavior on the result channel.
  typedef enum {RX_ALWAYS, RX_RANDOM, RX_PATTERN} rx_mode_t;

  logic clk;
  logic rst_n;

  dq_in_if  in_ch ();
  dq_out_if out_ch ();

  double_ended_queue DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Behavioral deque: ring of DEPTH entries, front index, one-past-rear index, fill count.
  data_t       deque_mem [DEPTH];
  int          front_idx = 0;
  int          rear_idx  = 0;
  int          held      = 0;

  // Results owed by the DUT, oldest first.
  dq_result_t  pending_results [$];

  rx_mode_t    rx_mode    = RX_ALWAYS;
  int unsigned gap_max    = 0;  // longest sender gap between bursts, 0 = no gaps
  int unsigned burst_left = 0;
  int unsigned failures   = 0;
  int unsigned results_seen = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #(LIMIT_NS);
    $display("tb: failure");
    $finish;
  end

  function automatic int wrap_inc(int idx);
    return (idx == DEPTH - 1) ? 0 : idx + 1;
  endfunction

  function automatic int wrap_dec(int idx);
    return (idx == 0) ? DEPTH - 1 : idx - 1;
  endfunction

  // Apply one operation to the behavioral deque and return the result it owes.
  function automatic dq_result_t apply_op(opcode_t op, data_t val);
    dq_result_t r;
    r.pop_value = '0;
    r.status    = ST_OK;
    if (op == OP_PUSH_REAR || op == OP_PUSH_FRONT) begin
      if (held >= DEPTH) begin
        r.status = ST_FULL;             // dropped, state untouched
      end else begin
        if (op == OP_PUSH_REAR) begin
          deque_mem[rear_idx] = val;
          rear_idx = wrap_inc(rear_idx);
        end else begin
          // front push on an empty deque also makes this the rear entry
          front_idx = wrap_dec(front_idx);
          deque_mem[front_idx] = val;
        end
        held++;
      end
    end else begin
      if (held == 0) begin
        r.status = ST_EMPTY;            // value stays zero
      end else begin
        if (op == OP_POP_FRONT) begin
          r.pop_value = deque_mem[front_idx];
          front_idx = wrap_inc(front_idx);
        end else begin
          rear_idx = wrap_dec(rear_idx);
          r.pop_value = deque_mem[rear_idx];
        end
        held--;
      end
    end
    r.occupancy = occ_t'(held);
    return r;
  endfunction

  task automatic report_failure(input string msg);
    failures++;
    if (failures <= 10) $display("tb: mismatch at result %0d: %s", results_seen, msg);
  endtask

  function automatic data_t pick_value();
    case ($urandom_range(0, 9))
      0:       return VAL_MIN;
      1:       return VAL_MAX;
      2:       return '0;
      3:       return '1;
      default: return data_t'($urandom);
    endcase
  endfunction

  function automatic opcode_t pick_op(int unsigned push_pct);
    logic at_front;
    at_front = $urandom_range(0, 1);
    if ($urandom_range(0, 99) < push_pct) return at_front ? OP_PUSH_FRONT : OP_PUSH_REAR;
    return at_front ? OP_POP_FRONT : OP_POP_REAR;
  endfunction

  // Result side: check each transfer against the oldest prediction, then pick next ready.
  initial begin : result_check
    dq_result_t  exp_r;
    int unsigned stall_left;
    logic [12:0] ready_pattern;
    stall_left    = 0;
    ready_pattern = 13'b1011011101101;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          report_failure("result with no operation outstanding");
        end else begin
          exp_r = pending_results.pop_front();
          if (out_ch.pop_value !== exp_r.pop_value)
            report_failure($sformatf("pop_value exp %0d got %0d",
                                     exp_r.pop_value, out_ch.pop_value));
          if (out_ch.status !== exp_r.status)
            report_failure($sformatf("status exp %0d got %0d", exp_r.status, out_ch.status));
          if (out_ch.occupancy !== exp_r.occupancy)
            report_failure($sformatf("occupancy exp %0d got %0d",
                                     exp_r.occupancy, out_ch.occupancy));
        end
      end
      case (rx_mode)
        RX_ALWAYS: out_ch.ready <= 1'b1;
        RX_RANDOM: out_ch.ready <= ($urandom_range(0, 3) != 0);
        default: begin
          // rotating pattern with an occasional long stall
          if (stall_left != 0) begin
            out_ch.ready <= 1'b0;
            stall_left--;
          end else begin
            out_ch.ready <= ready_pattern[0];
            ready_pattern = {ready_pattern[0], ready_pattern[12:1]};
            if ($urandom_range(0, 39) == 0) stall_left = $urandom_range(4, 16);
          end
        end
      endcase
    end
  end

  // One operation transfer. Valid stays high afterwards so back-to-back calls stream;
  // anything that burns time between calls must drop valid first.
  task automatic send_op(input opcode_t op, input data_t val);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    in_ch.valid      <= 1'b1;
    in_ch.opcode     <= op;
    in_ch.push_value <= val;
    do @(posedge clk); while (!in_ch.ready);
    pending_results.push_back(apply_op(op, val));
    burst_left--;
  endtask

  // Hold the sender off until every owed result has come back, then idle with valid low.
  task automatic wait_for_results();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic test_empty_pops();
    rx_mode = RX_ALWAYS;
    gap_max = 0;
    send_op(OP_POP_FRONT, VAL_MAX);
    send_op(OP_POP_REAR, VAL_MIN);
  endtask

  // Single entry seen from both ends; a front push into an empty deque must set the rear too.
  task automatic test_single_entry();
    send_op(OP_PUSH_FRONT, VAL_MAX);
    send_op(OP_POP_REAR, '0);
    send_op(OP_PUSH_REAR, VAL_MIN);
    send_op(OP_POP_FRONT, '1);
  endtask

  // Fill from both ends, then push onto a full deque at either end.
  task automatic test_fill_overflow();
    data_t fill_vals [4];
    fill_vals = '{VAL_MIN, VAL_MAX, data_t'(32'h5555_5555), data_t'(32'hAAAA_AAAA)};
    rx_mode = RX_RANDOM;
    for (int i = 0; i < DEPTH; i++)
      send_op((i % 2) ? OP_PUSH_FRONT : OP_PUSH_REAR, fill_vals[i % 4] ^ data_t'(i));
    send_op(OP_PUSH_REAR, '1);
    send_op(OP_PUSH_FRONT, '0);
  endtask

  // Phases of fill-heavy, drain-heavy and balanced traffic so full, empty and wrap recur.
  task automatic test_random_traffic(input int unsigned n_items);
    int unsigned sent;
    int unsigned phase_len;
    int unsigned push_pct;
    sent = 0;
    while (sent < n_items) begin
      phase_len = $urandom_range(8, 60);
      case ($urandom_range(0, 4))
        0:       push_pct = 85;
        1:       push_pct = 15;
        2:       push_pct = 65;
        3:       push_pct = 35;
        default: push_pct = 50;
      endcase
      case ($urandom_range(0, 2))
        0:       rx_mode = RX_ALWAYS;
        1:       rx_mode = RX_RANDOM;
        default: rx_mode = RX_PATTERN;
      endcase
      case ($urandom_range(0, 3))
        0:       gap_max = 0;
        1:       gap_max = 2;
        default: gap_max = 6;
      endcase
      for (int i = 0; i < phase_len && sent < n_items; i++) begin
        send_op(pick_op(push_pct), pick_value());
        sent++;
      end
    end
  endtask

  // Let the pipe run dry, then restart at full rate with no idling on either side.
  task automatic test_drain_restart();
    wait_for_results();
    rx_mode    = RX_ALWAYS;
    gap_max    = 0;
    burst_left = 0;
    for (int i = 0; i < 40; i++) send_op(pick_op(50), pick_value());
  endtask

  initial begin
    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.opcode     <= OP_PUSH_REAR;
    in_ch.push_value <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    test_empty_pops();
    test_single_entry();
    test_fill_overflow();
    test_random_traffic(600);
    test_drain_restart();
    test_random_traffic(660);

    wait_for_results();
    if (failures == 0 && pending_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* sim.f */
hdl/dq_pkg.sv
hdl/dq_if.sv
hdl/dq_cell.sv
hdl/double_ended_queue.sv
test/double_ended_queue_tb.sv
